// ----- design/mer_pkg.sv -----
`default_nettype none

package mer_pkg;

  localparam int CENTER_BITS = 12;
  localparam int RAD_BITS    = 11;
  localparam int SQ_BITS     = 22;
  localparam int WIDE_BITS   = 40;
  localparam int PIX_BITS    = 14;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_B,
    ST_A2B,
    ST_SLOPE,
    ST_ARM,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_E4,
    ST_E5,
    ST_E6,
    ST_PIX0,
    ST_PIX1,
    ST_PIX2,
    ST_PIX3,
    ST_FIN,
    ST_UPD1,
    ST_UPD2
  } mer_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_B,
    OP_A2B,
    OP_SLOPE,
    OP_ARM,
    OP_E1,
    OP_E2,
    OP_E3,
    OP_E4,
    OP_E5,
    OP_E6,
    OP_PIX0,
    OP_PIX1,
    OP_PIX2,
    OP_PIX3,
    OP_FIN,
    OP_UPD1,
    OP_UPD2
  } mer_op_t;

  typedef struct packed {
    logic    in_ready;
    mer_op_t op;
  } mer_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic active;
    logic region_two;
    logic slope_lt;
    logic y_zero;
    logic out_free;
  } mer_status_t;

endpackage

`default_nettype wire

// ----- design/mer_if.sv -----
`default_nettype none

interface mer_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [mer_pkg::CENTER_BITS-1:0]  center_x;
  logic [mer_pkg::CENTER_BITS-1:0]  center_y;
  logic [mer_pkg::RAD_BITS-1:0]     radius_x;
  logic [mer_pkg::RAD_BITS-1:0]     radius_y;

  modport source (output valid, mode, center_x, center_y, radius_x, radius_y, input ready);
  modport sink   (input valid, mode, center_x, center_y, radius_x, radius_y, output ready);
endinterface

interface mer_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mer_pkg::PIX_BITS-1:0] pixel_x;
  logic signed [mer_pkg::PIX_BITS-1:0] pixel_y;
  logic                                last_of_step;
  logic                                finished;

  modport source (output valid, pixel_x, pixel_y, last_of_step, finished, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, finished, output ready);
endinterface

`default_nettype wire

// ----- design/midpoint_ellipse_rasterizer.sv -----
// Start request: LOAD, then SQ_B, A2B, SLOPE and ARM; all but ARM use the shared multiplier.
// Step request: accept, pixel states PIX0-PIX3 (first pixel registered in PIX0), update states
// UPD1 and UPD2; UPD2 is skipped on the step that plots the last row, and the step that enters
// region two first runs E1-E6 (E1-E5 multiply); pixel states wait while the output is not free.
// Step while inactive: one finished result (FIN). One request in work at a time.
// rst (synchronous, high) clears the controller, the active and region flags and output valid.
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);

  mer_pkg::mer_cmd_t    cmd;
  mer_pkg::mer_status_t status;

  mer_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .status (status)
  );

  a_start_setup: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.mode == mer_pkg::MODE_START)
      |=> (cmd.op == mer_pkg::OP_SQ_B))
    else $error("start request did not begin setup");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mer_pkg::OP_PIX0 || cmd.op == mer_pkg::OP_PIX1 ||
     cmd.op == mer_pkg::OP_PIX2 || cmd.op == mer_pkg::OP_PIX3 ||
     cmd.op == mer_pkg::OP_FIN) |-> status.out_free)
    else $error("result written over a pending one");

  a_fin_shape: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.finished)
      |-> (out_ch.last_of_step && out_ch.pixel_x == '0 && out_ch.pixel_y == '0))
    else $error("malformed finished result");

  a_region_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mer_pkg::OP_E6) |=> status.region_two)
    else $error("region two not entered");

endmodule

`default_nettype wire

// ----- design/mer_ctrl.sv -----
`default_nettype none

module mer_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  mer_pkg::mer_status_t status,
  output mer_pkg::mer_cmd_t    cmd
);

  mer_pkg::mer_state_t state;
  mer_pkg::mer_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mer_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.in_ready = 1'b0;
    cmd.op       = mer_pkg::OP_NONE;
    unique case (state)
      mer_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          if (status.in_mode == mer_pkg::MODE_START) begin
            cmd.op     = mer_pkg::OP_LOAD;
            state_next = mer_pkg::ST_SQ_B;
          end else if (!status.active) begin
            state_next = mer_pkg::ST_FIN;
          end else if (!status.region_two && !status.slope_lt) begin
            state_next = mer_pkg::ST_E1;
          end else begin
            state_next = mer_pkg::ST_PIX0;
          end
        end
      end
      mer_pkg::ST_SQ_B: begin
        cmd.op     = mer_pkg::OP_SQ_B;
        state_next = mer_pkg::ST_A2B;
      end
      mer_pkg::ST_A2B: begin
        cmd.op     = mer_pkg::OP_A2B;
        state_next = mer_pkg::ST_SLOPE;
      end
      mer_pkg::ST_SLOPE: begin
        cmd.op     = mer_pkg::OP_SLOPE;
        state_next = mer_pkg::ST_ARM;
      end
      mer_pkg::ST_ARM: begin
        cmd.op     = mer_pkg::OP_ARM;
        state_next = mer_pkg::ST_IDLE;
      end
      mer_pkg::ST_E1: begin
        cmd.op     = mer_pkg::OP_E1;
        state_next = mer_pkg::ST_E2;
      end
      mer_pkg::ST_E2: begin
        cmd.op     = mer_pkg::OP_E2;
        state_next = mer_pkg::ST_E3;
      end
      mer_pkg::ST_E3: begin
        cmd.op     = mer_pkg::OP_E3;
        state_next = mer_pkg::ST_E4;
      end
      mer_pkg::ST_E4: begin
        cmd.op     = mer_pkg::OP_E4;
        state_next = mer_pkg::ST_E5;
      end
      mer_pkg::ST_E5: begin
        cmd.op     = mer_pkg::OP_E5;
        state_next = mer_pkg::ST_E6;
      end
      mer_pkg::ST_E6: begin
        cmd.op     = mer_pkg::OP_E6;
        state_next = mer_pkg::ST_PIX0;
      end
      mer_pkg::ST_PIX0: begin
        if (status.out_free) begin
          cmd.op     = mer_pkg::OP_PIX0;
          state_next = mer_pkg::ST_PIX1;
        end
      end
      mer_pkg::ST_PIX1: begin
        if (status.out_free) begin
          cmd.op     = mer_pkg::OP_PIX1;
          state_next = mer_pkg::ST_PIX2;
        end
      end
      mer_pkg::ST_PIX2: begin
        if (status.out_free) begin
          cmd.op     = mer_pkg::OP_PIX2;
          state_next = mer_pkg::ST_PIX3;
        end
      end
      mer_pkg::ST_PIX3: begin
        if (status.out_free) begin
          cmd.op     = mer_pkg::OP_PIX3;
          state_next = mer_pkg::ST_UPD1;
        end
      end
      mer_pkg::ST_FIN: begin
        if (status.out_free) begin
          cmd.op     = mer_pkg::OP_FIN;
          state_next = mer_pkg::ST_IDLE;
        end
      end
      mer_pkg::ST_UPD1: begin
        cmd.op = mer_pkg::OP_UPD1;
        if (status.region_two && status.y_zero) begin
          state_next = mer_pkg::ST_IDLE;
        end else begin
          state_next = mer_pkg::ST_UPD2;
        end
      end
      mer_pkg::ST_UPD2: begin
        cmd.op     = mer_pkg::OP_UPD2;
        state_next = mer_pkg::ST_IDLE;
      end
      default: begin
        state_next = mer_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/mer_datapath.sv -----
`default_nettype none

module mer_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  mer_in_if.sink               in_ch,
  mer_out_if.source            out_ch,
  input  mer_pkg::mer_cmd_t    cmd,
  output mer_pkg::mer_status_t status
);

  localparam int CB = COORD_BITS;
  localparam int WB = mer_pkg::WIDE_BITS;
  localparam int SB = mer_pkg::SQ_BITS;
  localparam int PB = mer_pkg::PIX_BITS;
  localparam int MA = (2 * COORD_BITS + 2 > mer_pkg::SQ_BITS) ?
                      2 * COORD_BITS + 2 : mer_pkg::SQ_BITS;

  logic [CB-1:0]                   offset_x;
  logic [CB-1:0]                   offset_y;
  logic [CB-1:0]                   saved_center_x;
  logic [CB-1:0]                   saved_center_y;
  logic [mer_pkg::RAD_BITS-1:0]    radius_b;
  logic [SB-1:0]                   axis_a_squared;
  logic [SB-1:0]                   axis_b_squared;
  logic [WB-1:0]                   slope_x;
  logic [WB-1:0]                   slope_y;
  logic [WB-1:0]                   decision;
  logic [WB-1:0]                   acc;
  logic [WB-1:0]                   prod;
  logic                            active;
  logic                            region_two;
  logic                            out_valid;
  logic signed [PB-1:0]            out_px;
  logic signed [PB-1:0]            out_py;
  logic                            out_last;
  logic                            out_fin;

  logic [MA-1:0]                   mul_a;
  logic [SB-1:0]                   mul_b;
  logic [MA+SB-1:0]                mul_full;
  logic [CB:0]                     t_odd;
  logic [CB-1:0]                   y_less;
  logic                            dec_neg;
  logic                            use_sx;
  logic                            use_sy;
  logic [WB-1:0]                   two_a2;
  logic [WB-1:0]                   two_b2;
  logic [WB-1:0]                   dec_term;
  logic [PB-1:0]                   cx_w;
  logic [PB-1:0]                   cy_w;
  logic [PB-1:0]                   ox_w;
  logic [PB-1:0]                   oy_w;
  logic [PB-1:0]                   x_plus;
  logic [PB-1:0]                   x_minus;
  logic [PB-1:0]                   y_plus;
  logic [PB-1:0]                   y_minus;
  logic                            out_free;
  logic                            emit;

  assign t_odd   = {offset_x, 1'b1};
  assign y_less  = (offset_y != '0) ? offset_y - CB'(1) : CB'(1);
  assign dec_neg = decision[WB-1];
  assign two_a2  = WB'({axis_a_squared, 1'b0});
  assign two_b2  = WB'({axis_b_squared, 1'b0});
  assign use_sx  = region_two ? dec_neg : 1'b1;
  assign use_sy  = region_two ? 1'b1 : !dec_neg;
  assign dec_term = (use_sx ? slope_x : '0) - (use_sy ? slope_y : '0)
                  + (region_two ? WB'(axis_a_squared) : WB'(axis_b_squared));

  assign cx_w    = PB'(saved_center_x);
  assign cy_w    = PB'(saved_center_y);
  assign ox_w    = PB'(offset_x);
  assign oy_w    = PB'(offset_y);
  assign x_plus  = cx_w + ox_w;
  assign x_minus = cx_w - ox_w;
  assign y_plus  = cy_w + oy_w;
  assign y_minus = cy_w - oy_w;

  assign emit = (cmd.op == mer_pkg::OP_PIX0) || (cmd.op == mer_pkg::OP_PIX1) ||
                (cmd.op == mer_pkg::OP_PIX2) || (cmd.op == mer_pkg::OP_PIX3) ||
                (cmd.op == mer_pkg::OP_FIN);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      mer_pkg::OP_LOAD: begin
        mul_a = MA'(in_ch.radius_x);
        mul_b = SB'(in_ch.radius_x);
      end
      mer_pkg::OP_SQ_B: begin
        mul_a = MA'(radius_b);
        mul_b = SB'(radius_b);
      end
      mer_pkg::OP_A2B: begin
        mul_a = MA'(axis_a_squared);
        mul_b = SB'(radius_b);
      end
      mer_pkg::OP_SLOPE: begin
        mul_a = MA'(axis_a_squared);
        mul_b = SB'(offset_y);
      end
      mer_pkg::OP_E1: begin
        mul_a = MA'(t_odd);
        mul_b = SB'(t_odd);
      end
      mer_pkg::OP_E2: begin
        mul_a = prod[MA-1:0];
        mul_b = axis_b_squared;
      end
      mer_pkg::OP_E3: begin
        mul_a = MA'(y_less);
        mul_b = SB'(y_less);
      end
      mer_pkg::OP_E4: begin
        mul_a = prod[MA-1:0];
        mul_b = axis_a_squared;
      end
      mer_pkg::OP_E5: begin
        mul_a = MA'(axis_b_squared);
        mul_b = axis_a_squared;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = (MA+SB)'(mul_a) * (MA+SB)'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      region_two <= 1'b0;
    end else begin
      unique case (cmd.op)
        mer_pkg::OP_LOAD: begin
          region_two <= 1'b0;
        end
        mer_pkg::OP_ARM: begin
          active <= 1'b1;
        end
        mer_pkg::OP_E6: begin
          region_two <= 1'b1;
        end
        mer_pkg::OP_UPD1: begin
          if (region_two && offset_y == '0) begin
            active <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mer_pkg::OP_LOAD: begin
        prod           <= mul_full[WB-1:0];
        saved_center_x <= CB'(in_ch.center_x);
        saved_center_y <= CB'(in_ch.center_y);
        radius_b       <= in_ch.radius_y;
        offset_x       <= '0;
        offset_y       <= CB'(in_ch.radius_y);
        slope_x        <= '0;
      end
      mer_pkg::OP_SQ_B: begin
        axis_a_squared <= prod[SB-1:0];
        prod           <= mul_full[WB-1:0];
      end
      mer_pkg::OP_A2B: begin
        axis_b_squared <= prod[SB-1:0];
        prod           <= mul_full[WB-1:0];
      end
      mer_pkg::OP_SLOPE: begin
        decision <= WB'({axis_b_squared, 2'b00}) + WB'(axis_a_squared) - (prod << 2);
        prod     <= mul_full[WB-1:0];
      end
      mer_pkg::OP_ARM: begin
        slope_y <= prod << 1;
      end
      mer_pkg::OP_E1, mer_pkg::OP_E2, mer_pkg::OP_E4: begin
        prod <= mul_full[WB-1:0];
      end
      mer_pkg::OP_E3: begin
        acc  <= prod;
        prod <= mul_full[WB-1:0];
      end
      mer_pkg::OP_E5: begin
        acc  <= acc + (prod << 2);
        prod <= mul_full[WB-1:0];
      end
      mer_pkg::OP_E6: begin
        decision <= acc - (prod << 2);
      end
      mer_pkg::OP_PIX0: begin
        out_px   <= x_plus;
        out_py   <= y_plus;
        out_last <= 1'b0;
        out_fin  <= 1'b0;
      end
      mer_pkg::OP_PIX1: begin
        out_px   <= x_minus;
        out_py   <= y_minus;
        out_last <= 1'b0;
        out_fin  <= 1'b0;
      end
      mer_pkg::OP_PIX2: begin
        out_px   <= x_plus;
        out_py   <= y_minus;
        out_last <= 1'b0;
        out_fin  <= 1'b0;
      end
      mer_pkg::OP_PIX3: begin
        out_px   <= x_minus;
        out_py   <= y_plus;
        out_last <= 1'b1;
        out_fin  <= 1'b0;
      end
      mer_pkg::OP_FIN: begin
        out_px   <= '0;
        out_py   <= '0;
        out_last <= 1'b1;
        out_fin  <= 1'b1;
      end
      mer_pkg::OP_UPD1: begin
        if (!region_two) begin
          offset_x <= offset_x + CB'(1);
          slope_x  <= slope_x + two_b2;
          if (!dec_neg) begin
            offset_y <= offset_y - CB'(1);
            slope_y  <= slope_y - two_a2;
          end
        end else if (offset_y != '0) begin
          offset_y <= offset_y - CB'(1);
          slope_y  <= slope_y - two_a2;
          if (dec_neg) begin
            offset_x <= offset_x + CB'(1);
            slope_x  <= slope_x + two_b2;
          end
        end
      end
      mer_pkg::OP_UPD2: begin
        decision <= decision + (dec_term << 2);
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready         = cmd.in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.pixel_x      = out_px;
  assign out_ch.pixel_y      = out_py;
  assign out_ch.last_of_step = out_last;
  assign out_ch.finished     = out_fin;

  assign status.in_valid   = in_ch.valid;
  assign status.in_mode    = in_ch.mode;
  assign status.active     = active;
  assign status.region_two = region_two;
  assign status.slope_lt   = slope_x < slope_y;
  assign status.y_zero     = (offset_y == '0);
  assign status.out_free   = out_free;

endmodule

`default_nettype wire
